>>> hw/rtl/itx_pkg.sv
// ----------------------------------------------------------------------------
// itx_pkg
// Shared widths, types and cofactor operand tables of the 3x3 inverse
// transpose unit.
// ----------------------------------------------------------------------------
package itx_pkg;

	// Number format of the matrix elements.
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	// Elements of one matrix, and of one result matrix.
	localparam int NL = 9;

	// Exact widths: element product, cofactor, determinant.
	localparam int PW     = 2 * DATA_WIDTH;
	localparam int CW     = PW + 1;
	localparam int DETW   = 3 * DATA_WIDTH + 3;

	// Determinant product split: cofactor low part unsigned, high part signed.
	localparam int LOW_W  = DATA_WIDTH;
	localparam int HIGH_W = CW - LOW_W;
	localparam int LOP_W  = DATA_WIDTH + LOW_W + 1;
	localparam int HIP_W  = DATA_WIDTH + HIGH_W;

	// Division: numerator is |cof| shifted left by SH, quotient has TB bits.
	localparam int SH     = 2 * FRAC_BITS + 1;
	localparam int TB     = DATA_WIDTH + 2;
	localparam int NW     = CW + SH;
	localparam int HW     = NW - TB;
	localparam int XW     = (HW > DETW) ? HW : DETW;
	localparam int RW     = DETW + 1;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [PW-1:0]         prod_t;
	typedef logic signed [CW-1:0]         cof_t;
	typedef logic signed [DETW-1:0]       det_t;
	typedef logic signed [LOP_W-1:0]      lop_t;
	typedef logic signed [HIP_W-1:0]      hip_t;
	typedef logic [CW-1:0]                cmag_t;
	typedef logic [DETW-1:0]              dmag_t;
	typedef logic [TB-1:0]                tq_t;

	// One classified transaction handed from the front to the back.
	typedef struct packed {
		cmag_t [NL-1:0] cmag;
		logic [NL-1:0]  neg;
		dmag_t          dmag;
		logic           singular;
	} work_t;

	// Cofactor n[i] = m[CA]*m[CB] - m[CC]*m[CD], row-major element indexes.
	localparam int unsigned CA [NL] = '{4, 6, 3, 7, 0, 6, 1, 3, 0};
	localparam int unsigned CB [NL] = '{8, 5, 7, 2, 8, 1, 5, 2, 4};
	localparam int unsigned CC [NL] = '{7, 3, 6, 1, 6, 0, 4, 0, 3};
	localparam int unsigned CD [NL] = '{5, 8, 4, 8, 2, 7, 2, 5, 1};

endpackage

>>> hw/rtl/itx_front.sv
// ----------------------------------------------------------------------------
// itx_front
// Accepts matrices, computes the exact cofactors and determinant, and
// classifies each transaction by sign and singularity.
// ----------------------------------------------------------------------------
module itx_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  itx_pkg::data_t      m_in [itx_pkg::NL],
	output itx_pkg::work_t      work,
	output logic                work_vld,
	input  logic                q_full
);
	import itx_pkg::*;

	logic  adv;
	logic  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	data_t m_s1 [NL];
	data_t mr_s2 [3], mr_s3 [3];
	prod_t pa_s2 [NL], pb_s2 [NL];
	cof_t  cof_s3 [NL], cof_s4 [NL], cof_s5 [NL], cof_s6 [NL];
	lop_t  lo_s4 [3];
	hip_t  hi_s4 [3];
	det_t  dp_s5 [3];
	det_t  det_s6;
	work_t work_s7;

	// The whole front moves together unless its last stage cannot drain.
	assign adv      = !v_s7 || !q_full;
	assign full     = !adv;
	assign work     = work_s7;
	assign work_vld = v_s7;

	// Valid bits of the front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Input register, element products, cofactors.
	always_ff @(posedge clk) begin
		if (adv) begin
			m_s1 <= m_in;
			for (int i = 0; i < NL; i++) begin
				pa_s2[i]  <= PW'(m_s1[CA[i]]) * PW'(m_s1[CB[i]]);
				pb_s2[i]  <= PW'(m_s1[CC[i]]) * PW'(m_s1[CD[i]]);
				cof_s3[i] <= CW'(pa_s2[i]) - CW'(pb_s2[i]);
				cof_s4[i] <= cof_s3[i];
				cof_s5[i] <= cof_s4[i];
				cof_s6[i] <= cof_s5[i];
			end
			for (int k = 0; k < 3; k++) begin
				mr_s2[k] <= m_s1[k];
				mr_s3[k] <= mr_s2[k];
			end
		end
	end

	// Determinant: row 0 against its cofactors, each product in two halves.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				lo_s4[k] <= LOP_W'(mr_s3[k]) *
					LOP_W'($signed({1'b0, cof_s3[k][LOW_W-1:0]}));
				hi_s4[k] <= HIP_W'(mr_s3[k]) *
					HIP_W'($signed(cof_s3[k][CW-1:LOW_W]));
				dp_s5[k] <= DETW'(lo_s4[k]) + (DETW'(hi_s4[k]) <<< LOW_W);
			end
			det_s6 <= dp_s5[0] + dp_s5[1] + dp_s5[2];
		end
	end

	// Classification: magnitudes, quotient signs and the singular flag.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NL; i++) begin
				work_s7.neg[i]  <= cof_s6[i][CW-1] ^ det_s6[DETW-1];
				work_s7.cmag[i] <= cof_s6[i][CW-1] ? cmag_t'(-cof_s6[i])
					: cmag_t'(cof_s6[i]);
			end
			work_s7.dmag     <= det_s6[DETW-1] ? dmag_t'(-det_s6) : dmag_t'(det_s6);
			work_s7.singular <= (det_s6 == '0);
		end
	end

endmodule

>>> hw/rtl/itx_queue.sv
// ----------------------------------------------------------------------------
// itx_queue
// Two-entry queue that decouples the front from the divider back end.
// ----------------------------------------------------------------------------
module itx_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  itx_pkg::work_t wdata,
	input  logic           rd,
	output itx_pkg::work_t rdata,
	output logic           q_empty,
	output logic           q_full
);
	import itx_pkg::*;

	work_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_wr, do_rd;

	assign q_empty = (cnt_q == 2'd0);
	assign q_full  = (cnt_q == 2'd2);
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign rdata   = mem_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) wp_q <= !wp_q;
			if (do_rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wdata;
	end

endmodule

>>> hw/rtl/itx_back.sv
// ----------------------------------------------------------------------------
// itx_back
// Nine-lane pipelined restoring divider with rounding, saturation and the
// output register.
// ----------------------------------------------------------------------------
module itx_back (
	input  logic                clk,
	input  logic                arst_n,
	input  itx_pkg::work_t      head,
	input  logic                head_vld,
	output logic                take,
	output itx_pkg::data_t      n_out [itx_pkg::NL],
	output logic                invertible,
	output logic                empty,
	input  logic                pop
);
	import itx_pkg::*;

	logic  adv;
	logic  v_s   [TB+1];
	dmag_t rem_s [TB+1][NL];
	tq_t   sh_s  [TB+1][NL];
	logic [NL-1:0] big_s  [TB+1];
	logic [NL-1:0] neg_s  [TB+1];
	dmag_t         dm_s   [TB+1];
	logic          sing_s [TB+1];
	logic          v_out_q;
	data_t         n_q [NL];
	logic          inv_q;
	dmag_t         rem0   [NL];
	tq_t           sh0    [NL];
	logic [NL-1:0] big0;

	// The back moves as one whenever the output register is free or popped.
	assign adv        = !v_out_q || pop;
	assign take       = adv && head_vld;
	assign empty      = !v_out_q;
	assign invertible = inv_q;
	assign n_out      = n_q;

	// Division setup: overflow check and initial partial remainder.
	always_comb begin
		logic [NW-1:0] num;
		logic [HW-1:0] hi;
		for (int l = 0; l < NL; l++) begin
			num     = {head.cmag[l], {SH{1'b0}}};
			hi      = num[NW-1:TB];
			big0[l] = (XW'(hi) >= XW'(head.dmag));
			rem0[l] = DETW'(hi);
			sh0[l]  = num[TB-1:0];
		end
	end

	// Valid bits of the divider stages and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= TB; j++) v_s[j] <= 1'b0;
			v_out_q <= 1'b0;
		end else if (adv) begin
			v_s[0] <= head_vld;
			for (int j = 1; j <= TB; j++) v_s[j] <= v_s[j-1];
			v_out_q <= v_s[TB];
		end
	end

	// Stage zero loads from the queue head.
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0]  <= rem0;
			sh_s[0]   <= sh0;
			big_s[0]  <= big0;
			neg_s[0]  <= head.neg;
			dm_s[0]   <= head.dmag;
			sing_s[0] <= head.singular;
		end
	end

	// One quotient bit per stage in every lane.
	for (genvar j = 1; j <= TB; j++) begin : g_step
		always_ff @(posedge clk) begin
			logic [RW-1:0] r2;
			logic          ge;
			if (adv) begin
				for (int l = 0; l < NL; l++) begin
					r2 = {rem_s[j-1][l], sh_s[j-1][l][TB-1]};
					ge = (r2 >= {1'b0, dm_s[j-1]});
					rem_s[j][l] <= ge ? DETW'(r2 - {1'b0, dm_s[j-1]}) : DETW'(r2);
					sh_s[j][l]  <= {sh_s[j-1][l][TB-2:0], ge};
				end
				big_s[j]  <= big_s[j-1];
				neg_s[j]  <= neg_s[j-1];
				dm_s[j]   <= dm_s[j-1];
				sing_s[j] <= sing_s[j-1];
			end
		end
	end

	// Round half away from zero, saturate, apply sign, zero when singular.
	always_ff @(posedge clk) begin
		logic [TB:0]   t1;
		tq_t           q;
		tq_t           lim;
		tq_t           mag;
		if (adv) begin
			for (int l = 0; l < NL; l++) begin
				t1  = (TB+1)'(sh_s[TB][l]) + (TB+1)'(1);
				q   = t1[TB:1];
				lim = neg_s[TB][l] ? (tq_t'(1) << (DATA_WIDTH-1))
					: ((tq_t'(1) << (DATA_WIDTH-1)) - tq_t'(1));
				mag = (big_s[TB][l] || (q > lim)) ? lim : q;
				if (sing_s[TB]) n_q[l] <= '0;
				else if (neg_s[TB][l]) n_q[l] <= data_t'(-mag);
				else n_q[l] <= data_t'(mag);
			end
			inv_q <= !sing_s[TB];
		end
	end

endmodule

>>> hw/rtl/inverse_transpose_3x3.sv
// Pipeline: 7 front stages, one queue write, 35 divider stages and the output
// register.
// Throughput: one matrix per cycle when nothing stalls; the nine division
// lanes resolve one quotient bit per pipeline stage.
// Reset: arst_n clears all valid bits and the queue; data registers are not
// reset.
// ----------------------------------------------------------------------------
// inverse_transpose_3x3
// Normal-matrix unit: cofactors of a 3x3 Q16.16 matrix over its determinant,
// rounded and saturated, with a singular flag.
// ----------------------------------------------------------------------------
module inverse_transpose_3x3 (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  itx_pkg::data_t m00, m01, m02, m10, m11, m12, m20, m21, m22,
	output logic           empty,
	input  logic           pop,
	output itx_pkg::data_t n00, n01, n02, n10, n11, n12, n20, n21, n22,
	output logic           invertible
);
	import itx_pkg::*;

	data_t m_in [NL];
	data_t n_out [NL];
	work_t work, head;
	logic  work_vld, q_full, q_empty, take;

	assign m_in = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
	assign n00 = n_out[0];
	assign n01 = n_out[1];
	assign n02 = n_out[2];
	assign n10 = n_out[3];
	assign n11 = n_out[4];
	assign n12 = n_out[5];
	assign n20 = n_out[6];
	assign n21 = n_out[7];
	assign n22 = n_out[8];

	// Front: products, cofactors, determinant, classification.
	itx_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .m_in(m_in),
		.work(work), .work_vld(work_vld), .q_full(q_full)
	);

	// Decoupling queue.
	itx_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(work_vld), .wdata(work), .rd(take),
		.rdata(head), .q_empty(q_empty), .q_full(q_full)
	);

	// Back: division lanes and output register.
	itx_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .head_vld(!q_empty),
		.take(take), .n_out(n_out), .invertible(invertible), .empty(empty),
		.pop(pop)
	);

`ifndef SYNTH
	// A singular transaction delivers an all-zero matrix; six of its elements are checked.
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !invertible |-> (n00 == '0) && (n11 == '0) && (n22 == '0)
			&& (n01 == '0) && (n12 == '0) && (n20 == '0))
		else $error("singular result carries nonzero elements");

	// The input side stalls only behind a full queue.
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> q_full)
		else $error("input stalled while the queue had room");

	// A stalled result holds its flag.
	a_hold_flag: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(invertible))
		else $error("waiting result changed");
`endif

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Inverse transpose unit testbench
// Streams 3x3 Q16.16 matrices through the normal-matrix unit and checks every
// result matrix against an exact wide-integer computation of the cofactors
// over the determinant, with rounding to nearest and saturation.
// ----------------------------------------------------------------------------
module testbench;
	import itx_pkg::*;

	localparam int N_RANDOM = 1900;
	localparam int TAIL     = 200;

	typedef logic signed [511:0] wide_t;

	typedef struct {
		data_t e [NL];
	} matrix_t;

	typedef struct {
		data_t e [NL];
		logic  inv;
	} normal_t;

	logic  clk;
	logic  arst_n;
	logic  push;
	logic  full;
	logic  empty;
	logic  pop;
	data_t m_in [NL];
	data_t n_out [NL];
	logic  invertible;

	matrix_t pending_matrices [$];
	normal_t expected_normals [$];
	int      mismatches;
	bit      stimulus_done;
	bit      hold_pop;
	bit      calm;

	inverse_transpose_3x3 i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.m00(m_in[0]), .m01(m_in[1]), .m02(m_in[2]),
		.m10(m_in[3]), .m11(m_in[4]), .m12(m_in[5]),
		.m20(m_in[6]), .m21(m_in[7]), .m22(m_in[8]),
		.empty(empty), .pop(pop),
		.n00(n_out[0]), .n01(n_out[1]), .n02(n_out[2]),
		.n10(n_out[3]), .n11(n_out[4]), .n12(n_out[5]),
		.n20(n_out[6]), .n21(n_out[7]), .n22(n_out[8]),
		.invertible(invertible)
	);

	// Clock.
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// One rounded, saturated quotient cof * 2^(2F) / det.
	function automatic data_t scaled_quotient(wide_t cof, wide_t det);
		bit    neg;
		wide_t c;
		wide_t d;
		wide_t q;
		wide_t lim;
		neg = (cof < 0) != (det < 0);
		c = (cof < 0) ? -cof : cof;
		d = (det < 0) ? -det : det;
		q = ((c <<< (2 * FRAC_BITS + 1)) + d) / (d <<< 1);
		lim = neg ? (wide_t'(1) <<< (DATA_WIDTH - 1)) : ((wide_t'(1) <<< (DATA_WIDTH - 1)) - 1);
		if (q > lim)
			q = lim;
		if (neg)
			q = -q;
		return data_t'(q[DATA_WIDTH-1:0]);
	endfunction

	// Exact cofactors and determinant, then the normal matrix.
	function automatic normal_t normal_of(matrix_t m);
		normal_t r;
		wide_t   a [NL];
		wide_t   cof [NL];
		wide_t   det;
		for (int i = 0; i < NL; i++)
			a[i] = wide_t'(m.e[i]);
		cof[0] = a[4] * a[8] - a[7] * a[5];
		cof[1] = a[6] * a[5] - a[3] * a[8];
		cof[2] = a[3] * a[7] - a[6] * a[4];
		cof[3] = a[7] * a[2] - a[1] * a[8];
		cof[4] = a[0] * a[8] - a[6] * a[2];
		cof[5] = a[6] * a[1] - a[0] * a[7];
		cof[6] = a[1] * a[5] - a[4] * a[2];
		cof[7] = a[3] * a[2] - a[0] * a[5];
		cof[8] = a[0] * a[4] - a[3] * a[1];
		det = a[0] * cof[0] + a[1] * cof[1] + a[2] * cof[2];
		r.inv = (det != 0);
		for (int i = 0; i < NL; i++)
			r.e[i] = r.inv ? scaled_quotient(cof[i], det) : '0;
		return r;
	endfunction

	function automatic data_t random_element(int mode);
		case (mode)
			0: return data_t'($urandom);
			1: return data_t'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
			2: return data_t'($signed($urandom_range(0, 16'hffff)) - 32'sh0000_8000);
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7fff_ffff;
					1: return 32'sh8000_0000;
					2: return 32'sh0001_0000;
					default: return '0;
				endcase
			end
		endcase
	endfunction

	function automatic matrix_t diagonal(data_t a, data_t b, data_t c);
		matrix_t m;
		foreach (m.e[i])
			m.e[i] = '0;
		m.e[0] = a;
		m.e[4] = b;
		m.e[8] = c;
		return m;
	endfunction

	// Stimulus: directed cases, then random matrices.
	initial begin
		matrix_t m;
		int      mode;
		pending_matrices.push_back(diagonal(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000));
		pending_matrices.push_back(diagonal(32'sh0002_0000, 32'sh0004_0000, -32'sh0001_0000));
		pending_matrices.push_back(diagonal('0, 32'sh0001_0000, 32'sh0001_0000));
		pending_matrices.push_back(diagonal(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
		pending_matrices.push_back(diagonal(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
		pending_matrices.push_back(diagonal(32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0001));
		pending_matrices.push_back(diagonal(32'sh0000_0001, 32'sh7fff_ffff, -32'sh0000_0001));
		pending_matrices.push_back(diagonal(32'sh0000_0003, 32'sh0001_0000, 32'sh0001_0000));
		pending_matrices.push_back(diagonal(32'sh0003_0000, 32'sh0003_0000, 32'sh0003_0000));
		pending_matrices.push_back(diagonal(-32'sh0003_0000, 32'sh0001_0000, 32'sh0001_0000));
		// All elements equal: singular.
		foreach (m.e[i])
			m.e[i] = 32'sh7fff_ffff;
		pending_matrices.push_back(m);
		foreach (m.e[i])
			m.e[i] = 32'sh8000_0000;
		pending_matrices.push_back(m);
		foreach (m.e[i])
			m.e[i] = '0;
		pending_matrices.push_back(m);
		foreach (m.e[i])
			m.e[i] = -32'sh0000_0001;
		pending_matrices.push_back(m);
		// Alternating extremes, then the most negative value at every fourth element.
		foreach (m.e[i])
			m.e[i] = (i % 2) ? 32'sh8000_0000 : 32'sh7fff_ffff;
		pending_matrices.push_back(m);
		foreach (m.e[i])
			m.e[i] = (i % 4 == 0) ? 32'sh8000_0000 : data_t'(i);
		pending_matrices.push_back(m);
		for (int k = 0; k < N_RANDOM; k++) begin
			mode = $urandom_range(0, 3);
			foreach (m.e[i])
				m.e[i] = random_element(mode);
			// Some singular matrices: repeat a row.
			if ($urandom_range(0, 15) == 0)
				for (int c = 0; c < 3; c++)
					m.e[6 + c] = m.e[c];
			pending_matrices.push_back(m);
		end
	end

	// Reset and pressure windows.
	initial begin
		arst_n = 1'b0;
		hold_pop = 1'b0;
		calm = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (300) @(posedge clk);
		hold_pop = 1'b1;
		repeat (400) @(posedge clk);
		hold_pop = 1'b0;
		repeat (1500) @(posedge clk);
		calm = 1'b1;
		repeat (1500) @(posedge clk);
		calm = 1'b0;
	end

	// Driver: offers the next matrix while it still has any.
	initial begin
		push = 1'b0;
		pop = 1'b0;
		foreach (m_in[i])
			m_in[i] = '0;
		stimulus_done = 1'b0;
	end

	always @(posedge clk) begin
		bit go;
		if (arst_n) begin
			if (push && !full) begin
				expected_normals.push_back(normal_of(pending_matrices.pop_front()));
			end
			go = (pending_matrices.size() > 0) && (calm || $urandom_range(0, 99) >= 34);
			push <= go;
			if (go)
				for (int i = 0; i < NL; i++)
					m_in[i] <= pending_matrices[0].e[i];
			if (pending_matrices.size() == 0)
				stimulus_done <= 1'b1;
		end
	end

	// Monitor: compares each popped transaction with the oldest expectation.
	always @(posedge clk) begin
		normal_t want;
		bit      bad;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_normals.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transaction at %0t", $realtime);
				end else begin
					want = expected_normals.pop_front();
					bad = (invertible !== want.inv);
					for (int i = 0; i < NL; i++)
						if (n_out[i] !== want.e[i])
							bad = 1'b1;
					if (bad) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch at %0t: invertible exp %0b got %0b",
								$realtime, want.inv, invertible);
							for (int i = 0; i < NL; i++)
								$display("  n[%0d] exp %h got %h", i, want.e[i], n_out[i]);
						end
					end
				end
			end
			pop <= !hold_pop && (calm || $urandom_range(0, 99) >= 34);
		end
	end

	// End of run.
	initial begin
		mismatches = 0;
		wait (arst_n === 1'b1);
		wait (stimulus_done && !push);
		wait (expected_normals.size() == 0);
		repeat (TAIL) @(posedge clk);
		if (mismatches == 0 && expected_normals.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule

>>> inverse_transpose_3x3.f
hw/rtl/itx_pkg.sv
hw/rtl/itx_front.sv
hw/rtl/itx_queue.sv
hw/rtl/itx_back.sv
hw/rtl/inverse_transpose_3x3.sv
tb/testbench.sv
